/* sv/rdf_pkg.sv */
// ----------------------------------------------------------------------------
// rdf_pkg
// Shared types and fixed widths of the RGB distance fitness core.
// ----------------------------------------------------------------------------
package rdf_pkg;

  localparam int CH_W     = 8;   // color channel
  localparam int SQ_W     = 18;  // sum of three squared channel differences
  localparam int SUM_W    = 40;  // distance accumulator
  localparam int FIT_W    = 34;  // fitness result
  localparam int FIT_FRAC = 16;  // fraction bits of fitness

  typedef struct packed {
    logic valid;
    logic last;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

endpackage

/* sv/rgb_distance_fitness_core.sv */
// ----------------------------------------------------------------------------
// rgb_distance_fitness_core
// Sums the Euclidean RGB distance of target/rendered pixel pairs and gives
// fitness = 4 * pixel count / distance sum on the last pixel of an image.
// ----------------------------------------------------------------------------
// Pixel requests are taken one per cycle. Each pair passes a squared-difference
// stage and a chain of 9 + DIST_FRAC_BITS square-root cells, one root bit per
// cell, before it reaches the accumulator. After a request marked last_pixel
// the input stalls until that image's result is in the output register: the
// pair drains the square-root chain, the serial divider works through its
// clog2(MAX_PIXELS+1) + 18 + DIST_FRAC_BITS numerator bits, and the result
// loads once the output register is free. A zero distance sum gives the
// saturated fitness with zero_distance set.
module rgb_distance_fitness_core #(
  parameter int MAX_PIXELS     = 65536,
  parameter int DIST_FRAC_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rdf_pkg::CH_W-1:0]    target_red_i,
  input  logic [rdf_pkg::CH_W-1:0]    target_green_i,
  input  logic [rdf_pkg::CH_W-1:0]    target_blue_i,
  input  logic [rdf_pkg::CH_W-1:0]    rendered_red_i,
  input  logic [rdf_pkg::CH_W-1:0]    rendered_green_i,
  input  logic [rdf_pkg::CH_W-1:0]    rendered_blue_i,
  input  logic                        last_pixel_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rdf_pkg::FIT_W-1:0]   fitness_o,
  output logic                        zero_distance_o
);
  import rdf_pkg::*;

  localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int ROOT_W = SQ_W / 2 + DIST_FRAC_BITS;
  localparam int RAD_W  = 2 * ROOT_W;

  logic                 in_acc;
  logic [CH_W-1:0]      dr, dg, db;
  logic [2*CH_W-1:0]    sqr, sqg, sqb;

  cell_ctl_t            s0_ctl_q;
  logic [SQ_W-1:0]      sq_sum_q;

  cell_ctl_t            ctl_w  [ROOT_W+1];
  logic [RAD_W-1:0]     rad_w  [ROOT_W+1];
  logic [ROOT_W:0]      rem_w  [ROOT_W+1];
  logic [ROOT_W-1:0]    root_w [ROOT_W+1];

  logic [SUM_W-1:0]     sum_q;
  logic [CNT_W-1:0]     count_q;
  logic [SUM_W:0]       sum_ext;
  logic [SUM_W-1:0]     sum_sat;
  logic [CNT_W-1:0]     count_next;
  logic                 div_start;
  logic                 zero_q;
  logic                 busy_q;

  logic                 div_done;
  logic [FIT_W-1:0]     div_quot;
  logic                 out_free;
  logic                 out_load;
  logic                 out_valid_q;
  logic [FIT_W-1:0]     fitness_q;
  logic                 zero_out_q;

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !busy_q;

  // squared channel differences
  assign dr  = (target_red_i >= rendered_red_i) ? target_red_i - rendered_red_i
                                                : rendered_red_i - target_red_i;
  assign dg  = (target_green_i >= rendered_green_i) ? target_green_i - rendered_green_i
                                                    : rendered_green_i - target_green_i;
  assign db  = (target_blue_i >= rendered_blue_i) ? target_blue_i - rendered_blue_i
                                                  : rendered_blue_i - target_blue_i;
  assign sqr = (2*CH_W)'(dr) * (2*CH_W)'(dr);
  assign sqg = (2*CH_W)'(dg) * (2*CH_W)'(dg);
  assign sqb = (2*CH_W)'(db) * (2*CH_W)'(db);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_ctl_q <= '0;
    end else begin
      s0_ctl_q.valid <= in_acc;
      s0_ctl_q.last  <= last_pixel_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_sum_q <= SQ_W'(sqr) + SQ_W'(sqg) + SQ_W'(sqb);
  end

  // square-root chain
  assign ctl_w[0]  = s0_ctl_q;
  assign rad_w[0]  = RAD_W'(sq_sum_q) << (2 * DIST_FRAC_BITS);
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    rdf_sqrt_cell #(
      .ROOT_W(ROOT_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_w[i]),
      .rad_i  (rad_w[i]),
      .rem_i  (rem_w[i]),
      .root_i (root_w[i]),
      .ctl_o  (ctl_w[i+1]),
      .rad_o  (rad_w[i+1]),
      .rem_o  (rem_w[i+1]),
      .root_o (root_w[i+1])
    );
  end

  // accumulate, saturating
  assign sum_ext    = {1'b0, sum_q} + (SUM_W + 1)'(root_w[ROOT_W]);
  assign sum_sat    = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign count_next = (count_q < CNT_W'(MAX_PIXELS)) ? count_q + 1'b1 : count_q;
  assign div_start  = ctl_w[ROOT_W].valid && ctl_w[ROOT_W].last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (ctl_w[ROOT_W].valid) begin
      if (ctl_w[ROOT_W].last) begin
        sum_q   <= '0;
        count_q <= '0;
      end else begin
        sum_q   <= sum_sat;
        count_q <= count_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      zero_q <= (sum_sat == '0);
    end
  end

  rdf_divider #(
    .CNT_W     (CNT_W),
    .FRAC_BITS (DIST_FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .count_i    (count_next),
    .divisor_i  (sum_sat),
    .take_i     (out_load),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // hold input until the result moves to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_acc && last_pixel_i) begin
      busy_q <= 1'b1;
    end else if (out_load) begin
      busy_q <= 1'b0;
    end
  end

  // output register
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = div_done && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      fitness_q  <= div_quot;
      zero_out_q <= zero_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fitness_o       = fitness_q;
  assign zero_distance_o = zero_out_q;

endmodule

/* sv/rdf_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// rdf_sqrt_cell
// One cell of the square-root chain: resolves one root bit per cell and
// hands remainder, partial root and remaining radicand to the next cell.
// ----------------------------------------------------------------------------
module rdf_sqrt_cell #(
  parameter int ROOT_W = 17
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rdf_pkg::cell_ctl_t      ctl_i,
  input  logic [2*ROOT_W-1:0]     rad_i,
  input  logic [ROOT_W:0]         rem_i,
  input  logic [ROOT_W-1:0]       root_i,
  output rdf_pkg::cell_ctl_t      ctl_o,
  output logic [2*ROOT_W-1:0]     rad_o,
  output logic [ROOT_W:0]         rem_o,
  output logic [ROOT_W-1:0]       root_o
);
  import rdf_pkg::*;

  localparam int RAD_W = 2 * ROOT_W;

  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] rem_sub;
  logic              ge;

  cell_ctl_t           ctl_q;
  logic [RAD_W-1:0]    rad_q;
  logic [ROOT_W:0]     rem_q;
  logic [ROOT_W-1:0]   root_q;

  assign rem_sh  = {rem_i, rad_i[RAD_W-1 -: 2]};
  assign trial   = (ROOT_W + 3)'({root_i, 2'b01});
  assign ge      = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= {rad_i[RAD_W-3:0], 2'b00};
    rem_q  <= ge ? rem_sub[ROOT_W:0] : rem_sh[ROOT_W:0];
    root_q <= {root_i[ROOT_W-2:0], ge};
  end

  assign ctl_o  = ctl_q;
  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

/* sv/rdf_divider.sv */
// ----------------------------------------------------------------------------
// rdf_divider
// Serial restoring divider: 4 * count, scaled to the fitness fraction, over
// the distance sum, one quotient bit per cycle, saturated to the result width.
// ----------------------------------------------------------------------------
module rdf_divider #(
  parameter int CNT_W     = 17,
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [CNT_W-1:0]            count_i,
  input  logic [rdf_pkg::SUM_W-1:0]   divisor_i,
  input  logic                        take_i,
  output logic                        done_o,
  output logic [rdf_pkg::FIT_W-1:0]   quotient_o
);
  import rdf_pkg::*;

  localparam int SHIFT  = 2 + FIT_FRAC + FRAC_BITS;
  localparam int NUM_W  = CNT_W + SHIFT;
  localparam int STEP_W = $clog2(NUM_W + 1);
  localparam int QW     = (NUM_W > FIT_W) ? NUM_W : FIT_W;
  localparam logic [FIT_W-1:0] FitMax = '1;

  div_state_e         state_q, state_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic [SUM_W-1:0]   rem_q, rem_d;
  logic [SUM_W-1:0]   den_q, den_d;
  logic [STEP_W-1:0]  cnt_q, cnt_d;
  logic [SUM_W:0]     rem_sh;
  logic [SUM_W:0]     rem_sub;
  logic               ge;
  logic [QW-1:0]      q_ext;

  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    cnt_q <= cnt_d;
  end

  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          num_d   = NUM_W'(count_i) << SHIFT;
          rem_d   = '0;
          den_d   = divisor_i;
          cnt_d   = STEP_W'(NUM_W);
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        rem_d = ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
        num_d = {num_q[NUM_W-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (take_i) begin
          state_d = DIV_IDLE;
        end
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  assign q_ext      = QW'(num_q);
  assign done_o     = (state_q == DIV_DONE);
  assign quotient_o = (q_ext > QW'(FitMax)) ? FitMax : q_ext[FIT_W-1:0];

endmodule

/* test/rgb_distance_fitness_core_test.sv */
// ----------------------------------------------------------------------------
// rgb_distance_fitness_core_test
// Streams target/rendered pixel pairs into the fitness core and checks every
// fitness result against a cycle-free predictor: the floor of the fixed-point
// Euclidean distance, the saturating distance sum and pixel count, and the
// saturating quotient. Directed images cover zero-distance and extreme-channel
// cases; random images follow with random gaps on the request side and
// random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_distance_fitness_core_test;

  import rdf_pkg::*;

  localparam int MAX_PIXELS     = 65536;
  localparam int DIST_FRAC_BITS = 8;
  localparam int RANDOM_PIXELS  = 1900;
  localparam int MAX_REPORTS    = 10;

  localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_W) - 1;
  localparam longint unsigned FIT_LIMIT = (64'd1 << FIT_W) - 1;

  typedef struct packed {
    logic [CH_W-1:0] tgt_r;
    logic [CH_W-1:0] tgt_g;
    logic [CH_W-1:0] tgt_b;
    logic [CH_W-1:0] ren_r;
    logic [CH_W-1:0] ren_g;
    logic [CH_W-1:0] ren_b;
    logic            last;
  } pixel_t;

  typedef struct packed {
    logic [FIT_W-1:0] fitness;
    logic             zero_distance;
  } fitness_t;

  typedef enum int {
    MIX_ANY,
    MIX_SAME,
    MIX_NEAR
  } content_e;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [CH_W-1:0]  target_red_i;
  logic [CH_W-1:0]  target_green_i;
  logic [CH_W-1:0]  target_blue_i;
  logic [CH_W-1:0]  rendered_red_i;
  logic [CH_W-1:0]  rendered_green_i;
  logic [CH_W-1:0]  rendered_blue_i;
  logic             last_pixel_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [FIT_W-1:0] fitness_o;
  logic             zero_distance_o;

  fitness_t         fitness_due[$];
  longint unsigned  dist_total;
  longint unsigned  px_tally;
  int               mismatches;
  int               pixels_sent;
  int               images_sent;
  int               results_seen;
  int               zero_results;
  int               saturated_results;
  bit               steady_source;
  bit               steady_sink;

  rgb_distance_fitness_core #(
    .MAX_PIXELS    (MAX_PIXELS),
    .DIST_FRAC_BITS(DIST_FRAC_BITS)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .target_red_i    (target_red_i),
    .target_green_i  (target_green_i),
    .target_blue_i   (target_blue_i),
    .rendered_red_i  (rendered_red_i),
    .rendered_green_i(rendered_green_i),
    .rendered_blue_i (rendered_blue_i),
    .last_pixel_i    (last_pixel_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .fitness_o       (fitness_o),
    .zero_distance_o (zero_distance_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned probe;
    res   = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v   -= res + probe;
        res  = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned sq_diff(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    longint signed d;
    d = longint'(a) - longint'(b);
    return longint'(d * d);
  endfunction

  function automatic longint unsigned pixel_distance(pixel_t px);
    longint unsigned s;
    s = sq_diff(px.tgt_r, px.ren_r) + sq_diff(px.tgt_g, px.ren_g)
      + sq_diff(px.tgt_b, px.ren_b);
    return root_floor(s << (2 * DIST_FRAC_BITS));
  endfunction

  task automatic tally_pixel(pixel_t px);
    longint unsigned total;
    longint unsigned num;
    longint unsigned q;
    fitness_t        res;
    total = dist_total + pixel_distance(px);
    dist_total = (total > SUM_LIMIT) ? SUM_LIMIT : total;
    if (px_tally < MAX_PIXELS) px_tally++;
    if (px.last) begin
      if (dist_total == 0) begin
        res.fitness       = FIT_W'(FIT_LIMIT);
        res.zero_distance = 1'b1;
      end else begin
        num = (4 * px_tally) << (FIT_FRAC + DIST_FRAC_BITS);
        q   = num / dist_total;
        res.fitness       = FIT_W'((q > FIT_LIMIT) ? FIT_LIMIT : q);
        res.zero_distance = 1'b0;
      end
      fitness_due = {fitness_due, res};
      dist_total = 0;
      px_tally   = 0;
      images_sent++;
    end
  endtask

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_pixel(pixel_t px);
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    target_red_i     <= px.tgt_r;
    target_green_i   <= px.tgt_g;
    target_blue_i    <= px.tgt_b;
    rendered_red_i   <= px.ren_r;
    rendered_green_i <= px.ren_g;
    rendered_blue_i  <= px.ren_b;
    last_pixel_i     <= px.last;
    do @(posedge clk_i); while (in_stall_o);
    pixels_sent++;
    tally_pixel(px);
  endtask

  task automatic idle_input(int n);
    if (n > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    idle_input(1);
    while (fitness_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic pixel_t make_pixel(logic [CH_W-1:0] tr, logic [CH_W-1:0] tg,
                                        logic [CH_W-1:0] tb, logic [CH_W-1:0] rr,
                                        logic [CH_W-1:0] rg, logic [CH_W-1:0] rb,
                                        logic last);
    pixel_t px;
    px.tgt_r = tr;
    px.tgt_g = tg;
    px.tgt_b = tb;
    px.ren_r = rr;
    px.ren_g = rg;
    px.ren_b = rb;
    px.last  = last;
    return px;
  endfunction

  function automatic logic [CH_W-1:0] near_of(logic [CH_W-1:0] v);
    int n;
    n = int'(v) + $urandom_range(0, 8) - 4;
    if (n < 0) n = 0;
    if (n > 255) n = 255;
    return CH_W'(n);
  endfunction

  function automatic pixel_t random_pixel(content_e mix, logic last);
    pixel_t px;
    px.tgt_r = CH_W'($urandom);
    px.tgt_g = CH_W'($urandom);
    px.tgt_b = CH_W'($urandom);
    case (mix)
      MIX_SAME: begin
        px.ren_r = px.tgt_r;
        px.ren_g = px.tgt_g;
        px.ren_b = px.tgt_b;
      end
      MIX_NEAR: begin
        px.ren_r = near_of(px.tgt_r);
        px.ren_g = near_of(px.tgt_g);
        px.ren_b = near_of(px.tgt_b);
      end
      default: begin
        px.ren_r = CH_W'($urandom);
        px.ren_g = CH_W'($urandom);
        px.ren_b = CH_W'($urandom);
      end
    endcase
    px.last = last;
    return px;
  endfunction

  initial begin : sink_stall
    @(posedge rst_ni);
    forever begin
      int n;
      n = steady_sink ? 0 : gap_cycles();
      if (n > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : fitness_check
    fitness_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (fitness_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result fitness=%0d zero_distance=%0b",
                   $realtime, fitness_o, zero_distance_o);
      end else begin
        want = fitness_due.pop_front();
        if (want.zero_distance) zero_results++;
        if (want.fitness == FIT_W'(FIT_LIMIT)) saturated_results++;
        if (fitness_o !== want.fitness || zero_distance_o !== want.zero_distance) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch fitness exp=%0d act=%0d, zero_distance exp=%0b act=%0b",
                     $realtime, want.fitness, fitness_o, want.zero_distance,
                     zero_distance_o);
        end
      end
    end
  end

  task automatic test_directed();
    steady_sink = 1'b0;
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1));
    wait_drained();
    send_pixel(make_pixel(8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 1'b1));
    send_pixel(make_pixel(8'd128, 8'd128, 8'd127, 8'd128, 8'd128, 8'd128, 1'b1));
    send_pixel(make_pixel(8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 1'b0));
    send_pixel(make_pixel(8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd8, 1'b1));
    send_pixel(make_pixel(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 1'b1));
    idle_input(5);
    for (int i = 0; i < 6; i++) send_pixel(random_pixel(MIX_ANY, i == 5));
    send_pixel(make_pixel(8'd200, 8'd10, 8'd90, 8'd199, 8'd12, 8'd93, 1'b1));
    wait_drained();
  endtask

  task automatic test_random_images();
    int       start;
    int       len;
    int       r;
    content_e mix;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      r = $urandom_range(0, 99);
      len = (r < 60) ? $urandom_range(1, 16) :
            (r < 90) ? $urandom_range(17, 64) : $urandom_range(65, 300);
      r = $urandom_range(0, 99);
      mix = (r < 70) ? MIX_ANY : (r < 82) ? MIX_SAME : MIX_NEAR;
      steady_source = ($urandom_range(0, 3) == 0);
      steady_sink   = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        send_pixel(random_pixel(mix, i == len - 1));
        if (!steady_source) idle_input(gap_cycles());
      end
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    steady_sink = 1'b0;
    wait_drained();
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    target_red_i     = '0;
    target_green_i   = '0;
    target_blue_i    = '0;
    rendered_red_i   = '0;
    rendered_green_i = '0;
    rendered_blue_i  = '0;
    last_pixel_i     = 1'b0;
    out_stall_i      = 1'b0;
    dist_total       = 0;
    px_tally         = 0;
    mismatches       = 0;
    pixels_sent      = 0;
    images_sent      = 0;
    results_seen     = 0;
    zero_results     = 0;
    saturated_results = 0;
    steady_source    = 1'b0;
    steady_sink      = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_images();

    idle_input(1);
    while (fitness_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Sent %0d pixel requests in %0d images; checked %0d results", pixels_sent,
             images_sent, results_seen);
    $display("(%0d zero-distance, %0d saturated), %0d mismatches", zero_results,
             saturated_results, mismatches);
    if (mismatches == 0 && fitness_due.size() == 0) begin
      $display("rgb_distance_fitness_core_test passed");
    end else begin
      $display("rgb_distance_fitness_core_test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("Timeout: %0d results still outstanding", fitness_due.size());
    $display("rgb_distance_fitness_core_test failed");
    $finish;
  end

endmodule
